>>> rtl/gfrm_pkg.sv
// Shared types and constants for the gain and frame RMS meter.
`timescale 1ns / 1ps
package gfrm_pkg;

   // Fixed field widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int LEVEL_W   = 16;
   // Shared multiplier: signed 18 x 18
   localparam int MUL_W     = 18;
   localparam int PROD_W    = 2 * MUL_W;
   // Gain is Q2.14
   localparam int FRAC_BITS = 14;
   // A squared Q1.15 sample is at most 2^30
   localparam int SQ_W      = 31;
   // Sixteen times the mean square is at most 2^34
   localparam int QUO_W     = 35;
   // Integer square root of a QUO_W value
   localparam int ROOT_W    = (QUO_W + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;

   localparam logic [GAIN_W-1:0]  GAIN_MAX   = 16'd32768;
   localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd16384;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'd32768;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 36'sd8192;
   localparam logic signed [PROD_W-FRAC_BITS-1:0] SAMPLE_POS_MAX = 22'sd32767;
   localparam logic signed [PROD_W-FRAC_BITS-1:0] SAMPLE_NEG_MAX = -22'sd32768;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       frame_end;
   } gfrm_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       level_valid;
      logic [LEVEL_W-1:0]         level;
   } gfrm_rsp_type;

   // Main sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SAT,
      ST_SQUARE,
      ST_ACCUM,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_SEND
   } gfrm_state_type;

   // Divide / square root unit
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIV,
      PH_SQRT,
      PH_DONE
   } gfrm_phase_type;

endpackage

>>> rtl/gfrm_root_unit.sv
// Bit-serial divider followed by a bit-serial square root on one shared subtractor.
`timescale 1ns / 1ps
module gfrm_root_unit #(
   parameter int MAX_FRAME = 4096,
   localparam int CNT_W = $clog2(MAX_FRAME + 1),
   localparam int DIV_W = 30 + CNT_W + 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIV_W-1:0]            dividend,
   input  logic [CNT_W-1:0]            divisor,
   output logic                        done,
   output logic [gfrm_pkg::ROOT_W-1:0] root
);
   import gfrm_pkg::*;

   localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;
   localparam int STEP_W = $clog2(DIV_W);

   gfrm_phase_type phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rm_ff, rm_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [CNT_W:0]    rem_shift;
   logic [ROOT_W+2:0] rm_shift;
   logic [ROOT_W+1:0] trial;
   logic [SUB_W-1:0]  sub_a, sub_b;
   logic [SUB_W:0]    diff;
   logic              ge;

   // Shared subtractor: divisor against partial remainder, or trial root against radicand
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DIV_W-1]};
      rm_shift  = {rm_ff, rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      if (phase_ff == PH_DIV) begin
         sub_a = SUB_W'(rem_shift);
         sub_b = SUB_W'(divisor);
      end else begin
         sub_a = SUB_W'(rm_shift);
         sub_b = SUB_W'(trial);
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[SUB_W];
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: if (start) phase_in = PH_DIV;
         PH_DIV:  if (step_ff == '0) phase_in = PH_SQRT;
         PH_SQRT: if (step_ff == '0) phase_in = PH_DONE;
         PH_DONE: phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rad_in  = rad_ff;
      rm_in   = rm_ff;
      root_in = root_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               dvd_in  = dividend;
               rem_in  = '0;
               quo_in  = '0;
               step_in = STEP_W'(DIV_W - 1);
            end
         end
         PH_DIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = ge ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], ge};
            if (step_ff == '0) begin
               rad_in  = RAD_W'({quo_ff[QUO_W-2:0], ge});
               rm_in   = '0;
               root_in = '0;
               step_in = STEP_W'(ROOT_W - 1);
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         PH_SQRT: begin
            rad_in  = rad_ff << 2;
            rm_in   = ge ? diff[ROOT_W:0] : rm_shift[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], ge};
            if (step_ff != '0) step_in = step_ff - 1'b1;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rad_ff  <= rad_in;
      rm_ff   <= rm_in;
      root_ff <= root_in;
   end

   assign done = (phase_ff == PH_DONE);
   assign root = root_ff;

   // Checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> phase_ff == PH_IDLE) else $error("root unit started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held longer than one cycle");
   a_sqrt_steps: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SQRT |-> step_ff < STEP_W'(ROOT_W))
      else $error("square root step count out of range");

endmodule

>>> rtl/gain_and_frame_rms_meter.sv
// Top level: volume scaling, square accumulation and frame level sequencer.
`timescale 1ns / 1ps
// Scales each Q1.15 sample by the Q2.14 volume (clamped to 2.0, rounded, saturated) and
// returns it with a level field that, on a frame's last sample, carries four times the
// frame RMS clamped to 1.0 (unsigned Q1.15). One sample is handled at a time: req_stall is low only
// while the block is idle, and the next sample is taken only once the result beat has left. Each
// sample passes through the scale, saturate, square and accumulate states, set by the single
// shared 18x18 multiplier being used once for the gain and once for the square. A frame-end
// sample also waits for the restoring divide and square root, which run one bit or one root
// digit per cycle on a shared subtractor. Samples beyond MAX_FRAME in a frame are passed
// through but not metered.
module gain_and_frame_rms_meter #(
   parameter int MAX_FRAME = 4096,
   localparam int CNT_W = $clog2(MAX_FRAME + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gfrm_pkg::gfrm_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gfrm_pkg::gfrm_rsp_type         rsp_data,
   input  logic                           csr_wr_en,
   input  logic [gfrm_pkg::GAIN_W-1:0]    csr_wr_data
);
   import gfrm_pkg::*;

   localparam int SUM_W = 30 + CNT_W;
   localparam int DIV_W = SUM_W + 4;
   localparam int YW_W  = PROD_W - FRAC_BITS;

   gfrm_state_type state_ff, state_in;

   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in_nx;
   logic                       last_ff, last_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   gfrm_rsp_type               rsp_ff, rsp_in;

   logic [GAIN_W-1:0]        gain_eff;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] rounded;
   logic signed [YW_W-1:0]   y_wide;
   logic                     root_start;
   logic                     root_done;
   logic [ROOT_W-1:0]        root_val;
   logic [LEVEL_W-1:0]       level_clamped;

   // Shared multiplier: gain product, then square of the scaled sample
   always_comb begin
      gain_eff = (gain_ff > GAIN_MAX) ? GAIN_MAX : gain_ff;
      if (state_ff == ST_SCALE) begin
         mul_a = MUL_W'(sample_ff);
         mul_b = $signed({2'b00, gain_eff});
      end else begin
         mul_a = MUL_W'(y_ff);
         mul_b = MUL_W'(y_ff);
      end
      mul_p = mul_a * mul_b;
   end

   // Round half up and saturate to Q1.15
   always_comb begin
      rounded = prod_ff + ROUND_HALF;
      y_wide  = rounded[PROD_W-1:FRAC_BITS];
   end

   assign level_clamped = (root_val > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root_val[LEVEL_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_SAT;
         ST_SAT:       state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_ACCUM;
         ST_ACCUM:     state_in = last_ff ? ST_ROOT_GO : ST_SEND;
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (root_done) state_in = ST_SEND;
         ST_SEND:      if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Handshake and unit control
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_SEND);
      root_start = (state_ff == ST_ROOT_GO);
   end

   // Datapath and meter state
   always_comb begin
      gain_in      = csr_wr_en ? csr_wr_data : gain_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      sample_in_nx = sample_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      y_in         = y_ff;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in_nx = req_data.sample_in;
               last_in      = req_data.frame_end;
            end
         end
         ST_SCALE: prod_in = mul_p;
         ST_SAT: begin
            if (y_wide > SAMPLE_POS_MAX) begin
               y_in = SAMPLE_POS_MAX[SAMPLE_W-1:0];
            end else if (y_wide < SAMPLE_NEG_MAX) begin
               y_in = SAMPLE_NEG_MAX[SAMPLE_W-1:0];
            end else begin
               y_in = y_wide[SAMPLE_W-1:0];
            end
         end
         ST_SQUARE: prod_in = mul_p;
         ST_ACCUM: begin
            if (count_ff < CNT_W'(MAX_FRAME)) begin
               sum_in   = sum_ff + SUM_W'(prod_ff[SQ_W-1:0]);
               count_in = count_ff + 1'b1;
            end
            rsp_in.sample_out  = y_ff;
            rsp_in.level_valid = last_ff;
            rsp_in.level       = '0;
         end
         ST_ROOT_WAIT: begin
            if (root_done) begin
               rsp_in.level = level_clamped;
               sum_in       = '0;
               count_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff  <= GAIN_RESET;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_nx;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      y_ff      <= y_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // Mean square times sixteen, then its root
   gfrm_root_unit #(
      .MAX_FRAME (MAX_FRAME)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .dividend ({sum_ff, 4'b0000}),
      .divisor  (count_ff),
      .done     (root_done),
      .root     (root_val)
   );

   // Checks
   a_busy_on_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while a result beat waits");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME)) else $error("sample count beyond frame limit");
   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.level_valid |-> rsp_data.level == '0)
      else $error("level set on a beat that is not a frame end");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ST_ROOT_WAIT) else $error("root result outside wait state");
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.level_valid |-> count_ff == '0 && sum_ff == '0)
      else $error("accumulator not cleared after frame end");

endmodule
